FILE: rtl/socd_pkg.sv
// ----------------------------------------------------------------------------
// socd_pkg
// shared types and constants for the opposing key pair resolver
// ----------------------------------------------------------------------------
package socd_pkg;

    localparam int SEQ_BITS   = 16;   // press sequence number width, 4 to 32
    localparam int TRAVEL_W   = 16;
    localparam int TIME_W     = 32;
    localparam int STAB_W     = 8;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HYST_UM    = 100;

    typedef enum logic [1:0] {
        KEY_A    = 2'd0,
        KEY_B    = 2'd1,
        KEY_NONE = 2'd2
    } t_key;

    typedef enum logic [1:0] {
        OP_PRESS     = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_TICK      = 2'd2,
        OP_RECONCILE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_LAST    = 3'd0,
        MODE_MOST    = 3'd1,
        MODE_PRIO_A  = 3'd2,
        MODE_PRIO_B  = 3'd3,
        MODE_NEUTRAL = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_EN    = 3'd0,
        CFG_MODE       = 3'd1,
        CFG_FULL_EN    = 3'd2,
        CFG_FULL_POINT = 3'd3,
        CFG_STAB_MS    = 3'd4
    } t_cfg_reg;

    // result of one most-pressed evaluation
    typedef struct packed {
        logic              sup_a;
        logic              sup_b;
        t_key              winner;
        t_key              cand;
        logic [TIME_W-1:0] since;
    } t_mp;

endpackage

FILE: rtl/socd_pair_resolver_unit.sv
// ----------------------------------------------------------------------------
// socd_pair_resolver_unit
// resolves simultaneous presses of one pair of opposing analog keys
// ----------------------------------------------------------------------------
// timing: a request moves from the request register to the result register
//   once the result register is free; a result held by the receiver adds its wait
// throughput: one request per cycle while the receiver takes results; the
//   resolution state commits on the edge that moves a request to the result register
// reset: synchronous, active low; clears configuration to defaults, the
//   resolution state, the sequence counter and both valid flags
module socd_pair_resolver_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [socd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [socd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_opcode,
    input  logic                                  i_which_key,
    input  logic                                  i_a_pressed,
    input  logic                                  i_b_pressed,
    input  logic signed [socd_pkg::TRAVEL_W-1:0]  i_a_travel,
    input  logic signed [socd_pkg::TRAVEL_W-1:0]  i_b_travel,
    input  logic [socd_pkg::TIME_W-1:0]           i_now_ms,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_suppress_a,
    output logic                                  o_suppress_b,
    output logic [1:0]                            o_winner_code,
    output logic                                  o_both_full
);
    import socd_pkg::*;

    localparam int EXT_W = TRAVEL_W + 2;   // room for travel plus hysteresis

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic              r_pair_en;
    logic [2:0]        r_mode;
    logic              r_full_en;
    logic [THR_W-1:0]  r_full_point;
    logic [STAB_W-1:0] r_stab_ms;

    // ------------------------------------------------------------------
    // resolution state
    // ------------------------------------------------------------------
    logic                r_sup_a, n_sup_a;
    logic                r_sup_b, n_sup_b;
    t_key                r_winner, n_winner;
    t_key                r_win_cand, n_win_cand;
    logic [TIME_W-1:0]   r_win_since, n_win_since;
    logic                r_full_flag, n_full_flag;
    t_key                r_full_cand, n_full_cand;
    logic [TIME_W-1:0]   r_full_since, n_full_since;
    logic [SEQ_BITS-1:0] r_seq_a, n_seq_a;
    logic [SEQ_BITS-1:0] r_seq_b, n_seq_b;
    logic [SEQ_BITS-1:0] r_next_seq, n_next_seq;

    // request register
    logic                       r_in_valid;
    t_op                        r_in_op;
    logic                       r_in_key;
    logic                       r_in_pa;
    logic                       r_in_pb;
    logic signed [TRAVEL_W-1:0] r_in_ta;
    logic signed [TRAVEL_W-1:0] r_in_tb;
    logic [TIME_W-1:0]          r_in_now;

    // result register
    logic       r_out_valid;
    logic       r_out_sup_a;
    logic       r_out_sup_b;
    logic [1:0] r_out_winner;
    logic       r_out_full;

    logic adv;   // request register hands its request to the result register

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;   // always ready; writes need no request in flight, no check

    // ------------------------------------------------------------------
    // configuration writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_en    <= 1'b0;
            r_mode       <= MODE_LAST;
            r_full_en    <= 1'b0;
            r_full_point <= THR_W'(3500);
            r_stab_ms    <= STAB_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PAIR_EN:    r_pair_en    <= i_cfg_data[0];
                CFG_MODE:       r_mode       <= i_cfg_data[2:0];
                CFG_FULL_EN:    r_full_en    <= i_cfg_data[0];
                CFG_FULL_POINT: r_full_point <= i_cfg_data[THR_W-1:0];
                CFG_STAB_MS:    r_stab_ms    <= i_cfg_data[STAB_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op  <= t_op'(i_opcode);
            r_in_key <= i_which_key;
            r_in_pa  <= i_a_pressed;
            r_in_pb  <= i_b_pressed;
            r_in_ta  <= i_a_travel;
            r_in_tb  <= i_b_travel;
            r_in_now <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // compare terms
    // ------------------------------------------------------------------
    logic [STAB_W-1:0]       stab;        // zero delay behaves as one ms
    logic signed [EXT_W-1:0] ta_x, tb_x;
    logic signed [EXT_W-1:0] thr_x, rel_x;
    logic                    a_ge_b, a_over, b_over;
    logic                    full_on, full_hold, full_want;
    logic                    other_pressed;
    logic [SEQ_BITS-1:0]     seq_diff;
    logic                    a_newer;
    logic [SEQ_BITS-1:0]     seq_inc;

    assign stab   = (r_stab_ms == '0) ? STAB_W'(1) : r_stab_ms;
    assign ta_x   = EXT_W'(r_in_ta);
    assign tb_x   = EXT_W'(r_in_tb);
    assign a_ge_b = ta_x >= tb_x;
    // switching away from the current winner needs a 100 um lead
    assign a_over = ta_x >= tb_x + EXT_W'(HYST_UM);
    assign b_over = tb_x >= ta_x + EXT_W'(HYST_UM);

    // unsigned threshold against signed travel; release point 100 um below
    assign thr_x  = $signed({2'b00, r_full_point});
    assign rel_x  = (r_full_point > THR_W'(HYST_UM))
                  ? $signed({2'b00, r_full_point - THR_W'(HYST_UM)})
                  : '0;
    assign full_on   = (ta_x >= thr_x) && (tb_x >= thr_x);
    assign full_hold = (ta_x > rel_x) && (tb_x > rel_x);
    assign full_want = r_full_flag ? full_hold : full_on;

    assign other_pressed = r_in_key ? r_in_pa : r_in_pb;

    function automatic logic [SEQ_BITS-1:0] seq_plus_one(logic [SEQ_BITS-1:0] s);
        logic [SEQ_BITS-1:0] v;
        v = s + SEQ_BITS'(1);
        return (v == '0) ? SEQ_BITS'(1) : v;   // zero is reserved for unseen
    endfunction

    // wrapping sequence compare, zero meaning never pressed
    assign seq_diff = r_seq_a - r_seq_b;
    assign a_newer  = (r_seq_a != '0)
                   && ((r_seq_b == '0) || ((seq_diff != '0) && !seq_diff[SEQ_BITS-1]));
    assign seq_inc  = seq_plus_one(r_next_seq);

    // one most-pressed evaluation
    function automatic t_mp most_pressed(t_key cur, t_key cand,
                                         logic [TIME_W-1:0] since,
                                         logic [TIME_W-1:0] now,
                                         logic [STAB_W-1:0] dly,
                                         logic ge, logic ao, logic bo);
        t_mp  r;
        t_key want;
        r.winner = cur;
        r.cand   = cand;
        r.since  = since;
        if (cur != KEY_A && cur != KEY_B) begin
            r.winner = ge ? KEY_A : KEY_B;
            r.cand   = KEY_NONE;
        end else begin
            want = cur;
            if (cur == KEY_A && bo) begin
                want = KEY_B;
            end else if (cur == KEY_B && ao) begin
                want = KEY_A;
            end
            if (want == cur) begin
                r.cand = KEY_NONE;
            end else if (cand != want) begin
                r.cand  = want;
                r.since = now;
            end else if ((now - since) >= TIME_W'(dly)) begin
                r.winner = want;
                r.cand   = KEY_NONE;
            end
        end
        r.sup_a = (r.winner == KEY_B);
        r.sup_b = (r.winner == KEY_A);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // fully pressed override, tick path
    // ------------------------------------------------------------------
    logic              fu_flag;
    t_key              fu_cand;
    logic [TIME_W-1:0] fu_since;
    t_key              tk_winner;   // winner seen by most-pressed on a tick
    t_key              tk_cand;

    always_comb begin
        fu_flag  = r_full_flag;
        fu_cand  = r_full_cand;
        fu_since = r_full_since;
        if (full_want == r_full_flag) begin
            fu_cand = KEY_NONE;
        end else if (r_full_cand != t_key'({1'b0, full_want})) begin
            fu_cand  = t_key'({1'b0, full_want});
            fu_since = r_in_now;
        end else if ((r_in_now - r_full_since) >= TIME_W'(stab)) begin
            fu_flag = full_want;
            fu_cand = KEY_NONE;
        end
        tk_winner = r_winner;
        tk_cand   = r_win_cand;
        // override just dropped: start from no winner
        if (r_full_en && !fu_flag && r_full_flag) begin
            tk_winner = KEY_NONE;
            tk_cand   = KEY_NONE;
        end
    end

    t_mp mp_tick, mp_rec;

    assign mp_tick = most_pressed(tk_winner, tk_cand, r_win_since, r_in_now, stab,
                                  a_ge_b, a_over, b_over);
    assign mp_rec  = most_pressed(r_winner, r_win_cand, r_win_since, r_in_now, stab,
                                  a_ge_b, a_over, b_over);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_sup_a      = r_sup_a;
        n_sup_b      = r_sup_b;
        n_winner     = r_winner;
        n_win_cand   = r_win_cand;
        n_win_since  = r_win_since;
        n_full_flag  = r_full_flag;
        n_full_cand  = r_full_cand;
        n_full_since = r_full_since;
        n_seq_a      = r_seq_a;
        n_seq_b      = r_seq_b;
        n_next_seq   = r_next_seq;
        case (r_in_op)
            OP_PRESS: begin
                // sequence is stamped even with the pair disabled
                if (r_in_key) n_seq_b = r_next_seq;
                else          n_seq_a = r_next_seq;
                n_next_seq = seq_inc;
                if (r_pair_en) begin
                    if (r_in_key) n_sup_b = 1'b0;
                    else          n_sup_a = 1'b0;
                    if (other_pressed) begin
                        case (r_mode)
                            MODE_LAST: begin
                                if (r_in_key) n_sup_a = 1'b1;
                                else          n_sup_b = 1'b1;
                            end
                            MODE_PRIO_A:  n_sup_b = 1'b1;
                            MODE_PRIO_B:  n_sup_a = 1'b1;
                            MODE_NEUTRAL: begin
                                n_sup_a = 1'b1;
                                n_sup_b = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_RELEASE: begin
                if (r_pair_en && r_mode <= 3'(MODE_NEUTRAL)) begin
                    if (r_in_key) begin
                        n_sup_b = 1'b0;
                        if (other_pressed) n_sup_a = 1'b0;
                    end else begin
                        n_sup_a = 1'b0;
                        if (other_pressed) n_sup_b = 1'b0;
                    end
                    n_winner    = !other_pressed ? KEY_NONE : (r_in_key ? KEY_A : KEY_B);
                    n_win_cand  = KEY_NONE;
                    n_full_flag = 1'b0;
                    n_full_cand = KEY_NONE;
                end
            end
            OP_TICK: begin
                if (r_pair_en && r_mode == 3'(MODE_MOST) && r_in_pa && r_in_pb) begin
                    if (r_full_en) begin
                        n_full_flag  = fu_flag;
                        n_full_cand  = fu_cand;
                        n_full_since = fu_since;
                    end
                    if (r_full_en && fu_flag) begin
                        n_sup_a    = 1'b0;
                        n_sup_b    = 1'b0;
                        n_win_cand = KEY_NONE;
                    end else begin
                        n_sup_a     = mp_tick.sup_a;
                        n_sup_b     = mp_tick.sup_b;
                        n_winner    = mp_tick.winner;
                        n_win_cand  = mp_tick.cand;
                        n_win_since = mp_tick.since;
                    end
                end
            end
            OP_RECONCILE: begin
                if (r_pair_en && r_in_pa && r_in_pb) begin
                    case (r_mode)
                        MODE_LAST: begin
                            n_winner = a_newer ? KEY_A : KEY_B;
                            n_sup_a  = !a_newer;
                            n_sup_b  = a_newer;
                        end
                        MODE_MOST: begin
                            n_sup_a     = mp_rec.sup_a;
                            n_sup_b     = mp_rec.sup_b;
                            n_winner    = mp_rec.winner;
                            n_win_cand  = mp_rec.cand;
                            n_win_since = mp_rec.since;
                        end
                        MODE_PRIO_A: begin
                            n_winner = KEY_A;
                            n_sup_a  = 1'b0;
                            n_sup_b  = 1'b1;
                        end
                        MODE_PRIO_B: begin
                            n_winner = KEY_B;
                            n_sup_a  = 1'b1;
                            n_sup_b  = 1'b0;
                        end
                        MODE_NEUTRAL: begin
                            n_sup_a    = 1'b1;
                            n_sup_b    = 1'b1;
                            n_winner   = KEY_NONE;
                            n_win_cand = KEY_NONE;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // state commits once per request as it moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sup_a      <= 1'b0;
            r_sup_b      <= 1'b0;
            r_winner     <= KEY_NONE;
            r_win_cand   <= KEY_NONE;
            r_win_since  <= '0;
            r_full_flag  <= 1'b0;
            r_full_cand  <= KEY_NONE;
            r_full_since <= '0;
            r_seq_a      <= '0;
            r_seq_b      <= '0;
            r_next_seq   <= SEQ_BITS'(1);
        end else if (adv) begin
            r_sup_a      <= n_sup_a;
            r_sup_b      <= n_sup_b;
            r_winner     <= n_winner;
            r_win_cand   <= n_win_cand;
            r_win_since  <= n_win_since;
            r_full_flag  <= n_full_flag;
            r_full_cand  <= n_full_cand;
            r_full_since <= n_full_since;
            r_seq_a      <= n_seq_a;
            r_seq_b      <= n_seq_b;
            r_next_seq   <= n_next_seq;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sup_a  <= n_sup_a;
            r_out_sup_b  <= n_sup_b;
            r_out_winner <= n_winner;
            r_out_full   <= n_full_flag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_suppress_a  = r_out_sup_a;
    assign o_suppress_b  = r_out_sup_b;
    assign o_winner_code = r_out_winner;
    assign o_both_full   = r_out_full;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_seq_never_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_seq != '0)
        else $error("press sequence counter reached the unseen code");

    a_press_advances_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_op == OP_PRESS) |=> r_next_seq != $past(r_next_seq))
        else $error("press request did not advance the sequence counter");

    a_other_keeps_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_op != OP_PRESS) |=> $stable(r_next_seq))
        else $error("non-press request changed the sequence counter");

    a_disabled_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_pair_en && r_in_op != OP_PRESS)
            |=> $stable(r_sup_a) && $stable(r_sup_b) && $stable(r_winner))
        else $error("disabled pair changed its resolution state");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("committed request left no result");

endmodule

FILE: verif/tb_socd_pair_resolver_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_socd_pair_resolver_unit
// self-checking bench for the opposing key pair resolver: a queue-fed request
// driver with random gaps, a result monitor with random stalls, and an
// in-bench model of the resolution state that predicts every result
// ----------------------------------------------------------------------------
module tb_socd_pair_resolver_unit;
    import socd_pkg::*;

    localparam int QUIET_LIMIT = 2000;       // cycles with no handshake at all
    localparam int CHUNK       = 30;         // requests between drain pauses
    localparam logic [2:0] MODE_UNDEF = 3'd7;

    // one request as the driver sees it
    typedef struct {
        t_op                 op;
        t_key                key;
        logic                a_dn;
        logic                b_dn;
        logic [TRAVEL_W-1:0] a_trv;
        logic [TRAVEL_W-1:0] b_trv;
        logic [TIME_W-1:0]   now;
    } t_key_event;

    // one result as the monitor sees it
    typedef struct {
        logic       sup_a;
        logic       sup_b;
        logic [1:0] winner;
        logic       both_full;
    } t_resolution;

    // ------------------------------------------------------------------
    // clock, reset and the signals driven into the unit
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                in_valid  = 1'b0;
    logic [1:0]          opcode    = '0;
    logic                which_key = 1'b0;
    logic                a_pressed = 1'b0;
    logic                b_pressed = 1'b0;
    logic [TRAVEL_W-1:0] a_travel  = '0;
    logic [TRAVEL_W-1:0] b_travel  = '0;
    logic [TIME_W-1:0]   now_ms    = '0;
    logic                out_ready = 1'b0;

    logic       o_cfg_ready, o_in_ready, o_out_valid;
    logic       o_suppress_a, o_suppress_b, o_both_full;
    logic [1:0] o_winner_code;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    socd_pair_resolver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (opcode),
        .i_which_key   (which_key),
        .i_a_pressed   (a_pressed),
        .i_b_pressed   (b_pressed),
        .i_a_travel    (a_travel),
        .i_b_travel    (b_travel),
        .i_now_ms      (now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_suppress_a  (o_suppress_a),
        .o_suppress_b  (o_suppress_b),
        .o_winner_code (o_winner_code),
        .o_both_full   (o_both_full)
    );

    // ------------------------------------------------------------------
    // bench state shared between the stimulus, driver and monitor
    // ------------------------------------------------------------------
    t_key_event  event_q[$];          // requests not yet offered
    t_resolution resolution_q[$];     // predicted results, oldest first
    t_key_event  cur_ev;              // request currently on the bus
    int          mismatches    = 0;
    int          src_wait      = 0;
    int          sink_wait     = 0;
    int          sink_hold     = 0;
    int          sink_hold_req = 0;   // long receiver stall asked by the stimulus
    bit          src_idle_on   = 1'b1;
    bit          sink_idle_on  = 1'b1;
    int          quiet_cycles  = 0;

    // configuration as the unit should hold it, reset defaults
    logic                c_pair_en    = 1'b0;
    logic [2:0]          c_mode       = MODE_LAST;
    logic                c_full_en    = 1'b0;
    logic [THR_W-1:0]    c_full_point = 16'd3500;
    logic [STAB_W-1:0]   c_stab       = 8'd1;

    // resolution state of the model, reset values
    logic                p_sup_a      = 1'b0;
    logic                p_sup_b      = 1'b0;
    t_key                p_winner     = KEY_NONE;
    t_key                p_cand       = KEY_NONE;
    logic [TIME_W-1:0]   p_cand_since = '0;
    logic                p_full       = 1'b0;
    logic [1:0]          p_full_cand  = KEY_NONE;   // holds 0, 1 or none
    logic [TIME_W-1:0]   p_full_since = '0;
    logic [SEQ_BITS-1:0] p_seq_a      = '0;         // zero means never pressed
    logic [SEQ_BITS-1:0] p_seq_b      = '0;
    logic [SEQ_BITS-1:0] p_seq_next   = SEQ_BITS'(1);

    // physical keyboard behind the well-formed traffic
    bit                kb_a = 1'b0;
    bit                kb_b = 1'b0;
    int                kb_ta = 0;
    int                kb_tb = 0;
    logic [TIME_W-1:0] kb_now = '0;

    // ------------------------------------------------------------------
    // resolution model
    // ------------------------------------------------------------------

    // stability window in ms, a zero setting behaves as one
    function automatic logic [TIME_W-1:0] stab_window();
        return (c_stab == 0) ? 32'd1 : {24'd0, c_stab};
    endfunction

    function automatic void grant_key(t_key w);
        if (w == KEY_A) begin
            p_sup_a = 1'b0;
            p_sup_b = 1'b1;
        end else begin
            p_sup_a = 1'b1;
            p_sup_b = 1'b0;
        end
        p_winner = w;
    endfunction

    // wrap-aware compare of press sequence numbers, zero never wins
    function automatic bit seq_is_newer(logic [SEQ_BITS-1:0] cand,
                                        logic [SEQ_BITS-1:0] older);
        logic [SEQ_BITS-1:0] d;
        if (cand == 0)
            return 1'b0;
        if (older == 0)
            return 1'b1;
        d = cand - older;
        return (d != 0) && !d[SEQ_BITS-1];
    endfunction

    // deeper key wins, a change needs 100 um lead held for the window
    function automatic void pick_most_pressed(int ta, int tb, logic [TIME_W-1:0] now);
        t_key cur;
        t_key want;
        if (p_winner != KEY_A && p_winner != KEY_B) begin
            grant_key((ta >= tb) ? KEY_A : KEY_B);
            p_cand = KEY_NONE;
            return;
        end
        cur = p_winner;
        grant_key(cur);
        want = cur;
        if (cur == KEY_A && tb >= ta + HYST_UM)
            want = KEY_B;
        else if (cur == KEY_B && ta >= tb + HYST_UM)
            want = KEY_A;
        if (want == cur) begin
            p_cand = KEY_NONE;
            return;
        end
        if (p_cand != want) begin
            p_cand       = want;
            p_cand_since = now;
            return;
        end
        if ((now - p_cand_since) < stab_window())
            return;
        grant_key(want);
        p_cand = KEY_NONE;
    endfunction

    // debounce of the both-fully-pressed flag
    function automatic void track_full_press(logic want, logic [TIME_W-1:0] now);
        if (want == p_full) begin
            p_full_cand = KEY_NONE;
            return;
        end
        if (p_full_cand != {1'b0, want}) begin
            p_full_cand  = {1'b0, want};
            p_full_since = now;
            return;
        end
        if ((now - p_full_since) < stab_window())
            return;
        p_full      = want;
        p_full_cand = KEY_NONE;
    endfunction

    // advances the model by one request and gives the result it must produce
    function automatic t_resolution resolve_event(t_key_event ev);
        t_resolution res;
        int          ta;
        int          tb;
        int          thr;
        int          rel;
        logic        was;
        logic        want;
        bit          handled;
        bit          partner_dn;
        ta = $signed(ev.a_trv);
        tb = $signed(ev.b_trv);
        partner_dn = (ev.key == KEY_A) ? ev.b_dn : ev.a_dn;
        case (ev.op)
            OP_PRESS: begin
                // sequence is taken even with the pair disabled
                if (ev.key == KEY_A)
                    p_seq_a = p_seq_next;
                else
                    p_seq_b = p_seq_next;
                p_seq_next = p_seq_next + SEQ_BITS'(1);
                if (p_seq_next == 0)
                    p_seq_next = SEQ_BITS'(1);
                if (c_pair_en) begin
                    if (ev.key == KEY_A)
                        p_sup_a = 1'b0;
                    else
                        p_sup_b = 1'b0;
                    if (partner_dn) begin
                        case (c_mode)
                            MODE_LAST: begin
                                if (ev.key == KEY_A)
                                    p_sup_b = 1'b1;
                                else
                                    p_sup_a = 1'b1;
                            end
                            MODE_PRIO_A: p_sup_b = 1'b1;
                            MODE_PRIO_B: p_sup_a = 1'b1;
                            MODE_NEUTRAL: begin
                                p_sup_a = 1'b1;
                                p_sup_b = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_RELEASE: begin
                if (c_pair_en && c_mode <= MODE_NEUTRAL) begin
                    if (ev.key == KEY_A) begin
                        p_sup_a = 1'b0;
                        if (partner_dn && p_sup_b)
                            p_sup_b = 1'b0;
                    end else begin
                        p_sup_b = 1'b0;
                        if (partner_dn && p_sup_a)
                            p_sup_a = 1'b0;
                    end
                    if (partner_dn)
                        p_winner = (ev.key == KEY_A) ? KEY_B : KEY_A;
                    else
                        p_winner = KEY_NONE;
                    p_cand      = KEY_NONE;
                    p_full      = 1'b0;
                    p_full_cand = KEY_NONE;
                end
            end
            OP_TICK: begin
                if (c_pair_en && c_mode == MODE_MOST && ev.a_dn && ev.b_dn) begin
                    handled = 1'b0;
                    if (c_full_en) begin
                        thr = c_full_point;
                        rel = (thr > HYST_UM) ? thr - HYST_UM : 0;
                        was = p_full;
                        want = was ? (ta > rel && tb > rel) : (ta >= thr && tb >= thr);
                        track_full_press(want, ev.now);
                        if (p_full) begin
                            p_sup_a = 1'b0;
                            p_sup_b = 1'b0;
                            p_cand  = KEY_NONE;
                            handled = 1'b1;
                        end else if (was) begin
                            p_winner = KEY_NONE;
                            p_cand   = KEY_NONE;
                        end
                    end
                    if (!handled)
                        pick_most_pressed(ta, tb, ev.now);
                end
            end
            default: begin
                if (c_pair_en && ev.a_dn && ev.b_dn) begin
                    case (c_mode)
                        MODE_LAST:
                            grant_key(seq_is_newer(p_seq_a, p_seq_b) ? KEY_A : KEY_B);
                        MODE_MOST:   pick_most_pressed(ta, tb, ev.now);
                        MODE_PRIO_A: grant_key(KEY_A);
                        MODE_PRIO_B: grant_key(KEY_B);
                        MODE_NEUTRAL: begin
                            p_sup_a  = 1'b1;
                            p_sup_b  = 1'b1;
                            p_winner = KEY_NONE;
                            p_cand   = KEY_NONE;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        res.sup_a     = p_sup_a;
        res.sup_b     = p_sup_b;
        res.winner    = p_winner;
        res.both_full = p_full;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request driver, also tracks register writes and feeds the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit busy;
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_wait = 0;
        end else begin
            // register write landed, mirror it
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_PAIR_EN:    c_pair_en    = cfg_data[0];
                    CFG_MODE:       c_mode       = cfg_data[2:0];
                    CFG_FULL_EN:    c_full_en    = cfg_data[0];
                    CFG_FULL_POINT: c_full_point = cfg_data[THR_W-1:0];
                    CFG_STAB_MS:    c_stab       = cfg_data[STAB_W-1:0];
                    default: ;
                endcase
            end
            busy = in_valid;
            // request taken: predict, then draw the gap before the next one
            if (in_valid && o_in_ready) begin
                resolution_q.push_back(resolve_event(cur_ev));
                busy = 1'b0;
                src_wait = src_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (!busy) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (event_q.size() != 0) begin
                    cur_ev = event_q.pop_front();
                    opcode    <= cur_ev.op;
                    which_key <= (cur_ev.key == KEY_B);
                    a_pressed <= cur_ev.a_dn;
                    b_pressed <= cur_ev.b_dn;
                    a_travel  <= cur_ev.a_trv;
                    b_travel  <= cur_ev.b_trv;
                    now_ms    <= cur_ev.now;
                    busy = 1'b1;
                end
            end
            // single update of valid per edge keeps back-to-back requests high
            in_valid <= busy;
        end
    end

    // ------------------------------------------------------------------
    // result monitor with random and long stalls
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin
        t_resolution exp_res;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (resolution_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    exp_res = resolution_q.pop_front();
                    if (o_suppress_a !== exp_res.sup_a)
                        report_mismatch("suppress_a", o_suppress_a, exp_res.sup_a);
                    if (o_suppress_b !== exp_res.sup_b)
                        report_mismatch("suppress_b", o_suppress_b, exp_res.sup_b);
                    if (o_winner_code !== exp_res.winner)
                        report_mismatch("winner_code", o_winner_code, exp_res.winner);
                    if (o_both_full !== exp_res.both_full)
                        report_mismatch("both_full", o_both_full, exp_res.both_full);
                end
                sink_wait = sink_idle_on ? $urandom_range(0, 7) : 0;
            end
            // long hold-off so the unit backs up into its input
            if (sink_hold_req > 0) begin
                sink_hold = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_ready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake means a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL socd_pair_resolver_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // all five registers, only called with the unit drained
    task automatic set_cfg(bit en, logic [2:0] mode, bit full_en,
                           logic [THR_W-1:0] point, logic [STAB_W-1:0] stab);
        write_reg(CFG_PAIR_EN, CFG_DATA_W'(en));
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_FULL_EN, CFG_DATA_W'(full_en));
        write_reg(CFG_FULL_POINT, CFG_DATA_W'(point));
        write_reg(CFG_STAB_MS, CFG_DATA_W'(stab));
    endtask

    task automatic put(t_op op, t_key k, bit a_dn, bit b_dn, int ta, int tb,
                       logic [TIME_W-1:0] now);
        t_key_event e;
        e.op    = op;
        e.key   = k;
        e.a_dn  = a_dn;
        e.b_dn  = b_dn;
        e.a_trv = ta[TRAVEL_W-1:0];
        e.b_trv = tb[TRAVEL_W-1:0];
        e.now   = now;
        event_q.push_back(e);
    endtask

    // wait until every request is out and every result back, plus latency
    task automatic wait_idle();
        @(negedge i_clk);
        while (event_q.size() != 0 || in_valid || resolution_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int clamp_travel(int v);
        return (v < -300) ? -300 : ((v > 4700) ? 4700 : v);
    endfunction

    // mostly well-formed key activity around the thresholds, some raw noise
    task automatic add_traffic(int count, int noise_pct);
        t_key_event e;
        int         r;
        int         step_max;
        int         thr;
        step_max = int'(stab_window()) + 2;
        thr = (c_full_point > 16'd4400) ? 3500 : int'(c_full_point);
        repeat (count) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                e.op    = t_op'($urandom_range(0, 3));
                e.key   = t_key'($urandom_range(0, 1));
                e.a_dn  = 1'($urandom_range(0, 1));
                e.b_dn  = 1'($urandom_range(0, 1));
                e.a_trv = TRAVEL_W'($urandom);
                e.b_trv = TRAVEL_W'($urandom);
                e.now   = $urandom;
                event_q.push_back(e);
            end else begin
                r = $urandom_range(0, 99);
                kb_now += $urandom_range(0, step_max);
                // ticks and reconciles want both keys down, press first
                if (r >= 22 && !(kb_a && kb_b))
                    r = 0;
                if (r < 12) begin
                    e.key = !kb_a ? KEY_A : (!kb_b ? KEY_B : t_key'($urandom_range(0, 1)));
                    if (e.key == KEY_A) begin
                        kb_a = 1'b1;
                        kb_ta = $urandom_range(100, 1500);
                    end else begin
                        kb_b = 1'b1;
                        kb_tb = $urandom_range(100, 1500);
                    end
                    put(OP_PRESS, e.key, kb_a, kb_b, kb_ta, kb_tb, kb_now);
                end else if (r < 22) begin
                    e.key = t_key'($urandom_range(0, 1));
                    if (e.key == KEY_A) begin
                        kb_a = 1'b0;
                        kb_ta = 0;
                    end else begin
                        kb_b = 1'b0;
                        kb_tb = 0;
                    end
                    put(OP_RELEASE, e.key, kb_a, kb_b, kb_ta, kb_tb, kb_now);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        // hover around the full press point
                        kb_ta = thr + int'($urandom_range(0, 300)) - 150;
                        kb_tb = thr + int'($urandom_range(0, 300)) - 150;
                    end else if (r < 25) begin
                        // lead close to the hysteresis step
                        kb_tb = clamp_travel(kb_ta + int'($urandom_range(0, 240)) - 120);
                    end else begin
                        kb_ta = clamp_travel(kb_ta + int'($urandom_range(0, 400)) - 200);
                        kb_tb = clamp_travel(kb_tb + int'($urandom_range(0, 400)) - 200);
                    end
                    if ($urandom_range(0, 19) == 0) begin
                        put(OP_TICK, KEY_A, 1'b1, 1'b1, $urandom_range(0, 1) ? 32767 : -32768,
                            $urandom_range(0, 1) ? 32767 : -32768, kb_now);
                    end else begin
                        put(($urandom_range(0, 5) == 0) ? OP_RECONCILE : OP_TICK,
                            t_key'($urandom_range(0, 1)), 1'b1, 1'b1, kb_ta, kb_tb, kb_now);
                    end
                end
            end
        end
    endtask

    // random traffic in chunks; the sender pauses for a full drain in between
    task automatic traffic_phase(int count, int noise_pct);
        int n;
        while (count > 0) begin
            n = (count > CHUNK) ? CHUNK : count;
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            add_traffic(n, noise_pct);
            wait_idle();
            count -= n;
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [2:0]       mode;
        logic [THR_W-1:0] point;
        logic [STAB_W-1:0] stab;
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: pair disabled, presses still take sequence numbers
        put(OP_PRESS, KEY_A, 1, 0, 0, 0, 32'd0);
        put(OP_PRESS, KEY_B, 1, 1, 32767, -32768, 32'hFFFF_FFFF);
        put(OP_TICK, KEY_A, 1, 1, -32768, 32767, 32'd5);
        put(OP_RECONCILE, KEY_B, 1, 1, 100, 200, 32'd6);
        put(OP_RELEASE, KEY_B, 1, 0, 100, 0, 32'd7);
        wait_idle();

        // last input wins
        set_cfg(1'b1, MODE_LAST, 1'b0, 16'd3500, 8'd1);
        put(OP_PRESS, KEY_A, 1, 0, 800, 0, 32'd10);
        put(OP_PRESS, KEY_B, 1, 1, 800, 900, 32'd11);
        put(OP_RECONCILE, KEY_A, 1, 1, 800, 900, 32'd12);
        put(OP_RELEASE, KEY_B, 1, 0, 800, 0, 32'd13);
        put(OP_PRESS, KEY_B, 1, 1, 800, 700, 32'd14);
        put(OP_PRESS, KEY_A, 1, 1, 800, 700, 32'd15);
        put(OP_RECONCILE, KEY_B, 1, 1, 800, 700, 32'd16);
        put(OP_RELEASE, KEY_A, 0, 1, 0, 700, 32'd17);
        wait_idle();
        traffic_phase(60, 15);

        // most pressed with full press override, hysteresis and delay
        set_cfg(1'b1, MODE_MOST, 1'b1, 16'd3500, 8'd2);
        put(OP_TICK, KEY_A, 1, 1, 1000, 500, 32'd100);
        put(OP_TICK, KEY_A, 1, 1, 1000, 1099, 32'd100);
        put(OP_TICK, KEY_A, 1, 1, 1000, 1100, 32'd101);
        put(OP_TICK, KEY_A, 1, 1, 1000, 1100, 32'd102);
        put(OP_TICK, KEY_A, 1, 1, 1000, 1100, 32'd103);
        put(OP_TICK, KEY_A, 1, 1, 3600, 3600, 32'd104);
        put(OP_TICK, KEY_A, 1, 1, 3600, 3600, 32'd106);
        put(OP_TICK, KEY_A, 1, 1, 3450, 3450, 32'd107);
        put(OP_TICK, KEY_A, 1, 1, 3300, 3500, 32'd108);
        put(OP_TICK, KEY_A, 1, 1, 3300, 3500, 32'd110);
        put(OP_TICK, KEY_A, 1, 1, 32767, -32768, 32'hFFFF_FFFF);
        put(OP_TICK, KEY_A, 1, 1, -32768, 32767, 32'd0);
        put(OP_TICK, KEY_A, 1, 1, -32768, 32767, 32'd1);
        put(OP_RECONCILE, KEY_A, 1, 1, 2000, 100, 32'd2);
        put(OP_RELEASE, KEY_A, 0, 1, 0, 100, 32'd3);
        wait_idle();
        kb_now = $urandom;
        traffic_phase(60, 10);

        // threshold beyond any signed travel, zero delay acts as one
        set_cfg(1'b1, MODE_MOST, 1'b1, 16'hFFFF, 8'd0);
        traffic_phase(60, 10);

        // release point floors at zero, longest delay, time wraps
        set_cfg(1'b1, MODE_MOST, 1'b1, 16'd50, 8'hFF);
        kb_now = 32'hFFFF_FF00;
        traffic_phase(60, 10);

        set_cfg(1'b1, MODE_MOST, 1'b0, 16'd1, 8'd1);
        traffic_phase(40, 10);
        set_cfg(1'b1, MODE_PRIO_A, 1'b1, 16'd3500, 8'd1);
        traffic_phase(40, 10);
        set_cfg(1'b1, MODE_PRIO_B, 1'b0, 16'd3500, 8'd1);
        traffic_phase(40, 10);
        set_cfg(1'b1, MODE_NEUTRAL, 1'b1, 16'd3500, 8'd3);
        traffic_phase(40, 10);
        // undefined mode resolves nothing
        set_cfg(1'b1, MODE_UNDEF, 1'b1, 16'd3500, 8'd1);
        traffic_phase(30, 10);
        set_cfg(1'b0, MODE_MOST, 1'b1, 16'd3500, 8'd1);
        traffic_phase(30, 10);

        // backpressure: receiver holds off while the sender keeps offering
        set_cfg(1'b1, MODE_MOST, 1'b1, 16'd3500, 8'd3);
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold_req = 80;
        add_traffic(40, 5);
        wait_idle();

        // dense presses with reconciles in last input mode
        set_cfg(1'b1, MODE_LAST, 1'b0, 16'd3500, 8'd1);
        for (int i = 0; i < 24; i++) begin
            if (i % 8 == 7)
                put(OP_RECONCILE, KEY_A, 1, 1, 500, 500, TIME_W'(i));
            else
                put(OP_PRESS, t_key'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 500, 500, TIME_W'(i));
        end
        wait_idle();

        // random settings
        repeat (3) begin
            mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0:       point = THR_W'($urandom_range(1, 65535));
                1:       point = THR_W'($urandom_range(1, 150));
                default: point = THR_W'($urandom_range(3000, 4000));
            endcase
            stab = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 5));
            set_cfg($urandom_range(0, 9) != 0, mode, 1'($urandom_range(0, 1)), point, stab);
            kb_now = $urandom;
            traffic_phase(30, 15);
        end

        // drained already; leave room for any stray late result
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS socd_pair_resolver_unit");
        else
            $display("FAIL socd_pair_resolver_unit");
        $finish;
    end

endmodule

FILE: files.f
rtl/socd_pkg.sv
rtl/socd_pair_resolver_unit.sv
verif/tb_socd_pair_resolver_unit.sv
